FILE: design/bbmc_pkg.sv
`timescale 1ns / 1ps

package bbmc_pkg;

   localparam int LEVEL_W   = 16;
   localparam int TEMP_W    = 11;
   localparam int PCT_W     = 7;
   localparam int MODE_W    = 3;
   localparam int LAMPS     = 5;
   localparam int HOLD_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_PRESENT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_EMPTY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_FULL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_START    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_STOP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_START    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_STOP     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LIMIT      = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [LEVEL_W-1:0]       RST_BATTERY_PRESENT = 16'd9000;
   localparam logic [LEVEL_W-1:0]       RST_BATTERY_EMPTY   = 16'd11000;
   localparam logic [LEVEL_W-1:0]       RST_BATTERY_FULL    = 16'd13800;
   localparam logic [LEVEL_W-1:0]       RST_SUPPLY_START    = 16'd11500;
   localparam logic [LEVEL_W-1:0]       RST_SUPPLY_STOP     = 16'd12500;
   localparam logic [LEVEL_W-1:0]       RST_CHARGE_START    = 16'd13000;
   localparam logic [LEVEL_W-1:0]       RST_CHARGE_STOP     = 16'd12300;
   localparam logic signed [TEMP_W-1:0] RST_TEMP_LIMIT      = 11'sd450;

   // Fixed thresholds.
   localparam logic signed [TEMP_W-1:0] HEATER_LEVEL           = 11'sd50;
   localparam logic signed [TEMP_W-1:0] CHARGE_MIN_TEMPERATURE = 11'sd0;
   localparam logic [LEVEL_W-1:0]       MIN_CHARGE_CURRENT     = 16'd100;
   localparam logic [PCT_W-1:0]         LAMP_LIMIT [LAMPS]     = '{7'd10, 7'd30, 7'd50,
                                                                   7'd70, 7'd90};

   // Hold-off loads.
   localparam logic [HOLD_W-1:0] HOLD_MODE_CHANGE = 4'd8;
   localparam logic [HOLD_W-1:0] HOLD_RELAY_CLOSE = 4'd6;
   localparam logic [HOLD_W-1:0] HOLD_RELAY_RETRY = 4'd4;

   // Mode codes as they appear on the result channel.
   localparam logic [MODE_W-1:0] MODE_CODE_INITIAL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_READY     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_SUPPLYING = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CODE_EMPTY     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CODE_CHARGING  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CODE_FULL      = 3'd5;

   typedef enum logic [5:0] {
      MODE_INITIAL   = 6'b000001,
      MODE_READY     = 6'b000010,
      MODE_SUPPLYING = 6'b000100,
      MODE_EMPTY     = 6'b001000,
      MODE_CHARGING  = 6'b010000,
      MODE_FULL      = 6'b100000
   } mode_type;

   typedef struct packed {
      logic chg_led;
      logic dis_led;
      logic fan;
      logic boost;
      logic heater;
      logic buck_off;
      logic chg_relay;
   } relay_type;

   localparam relay_type RELAY_RESET = '{chg_led: 1'b0, dis_led: 1'b0, fan: 1'b0,
                                         boost: 1'b0, heater: 1'b0, buck_off: 1'b1,
                                         chg_relay: 1'b0};

   typedef struct packed {
      mode_type           mode;
      logic [HOLD_W-1:0]  holdoff;
      logic               blink;
      logic               charging;
      relay_type          relays;
      logic [LAMPS-1:0]   lamps;
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]       battery_present;
      logic [LEVEL_W-1:0]       battery_empty;
      logic [LEVEL_W-1:0]       battery_full;
      logic [LEVEL_W-1:0]       supply_start;
      logic [LEVEL_W-1:0]       supply_stop;
      logic [LEVEL_W-1:0]       charge_start;
      logic [LEVEL_W-1:0]       charge_stop;
      logic signed [TEMP_W-1:0] temp_limit;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]       system_level;
      logic [LEVEL_W-1:0]       battery_level;
      logic signed [TEMP_W-1:0] battery_temperature;
      logic [LEVEL_W-1:0]       current_magnitude;
      logic [PCT_W-1:0]         charge_percent;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              charge_relay;
      logic              buck_output_off;
      logic              heater_relay;
      logic              boost_input_relay;
      logic              fan_on;
      logic              discharge_led;
      logic              charge_led;
      logic [LAMPS-1:0]  level_leds;
   } rsp_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] c;
      unique case (m)
         MODE_INITIAL:   c = MODE_CODE_INITIAL;
         MODE_READY:     c = MODE_CODE_READY;
         MODE_SUPPLYING: c = MODE_CODE_SUPPLYING;
         MODE_EMPTY:     c = MODE_CODE_EMPTY;
         MODE_CHARGING:  c = MODE_CODE_CHARGING;
         MODE_FULL:      c = MODE_CODE_FULL;
         default:        c = MODE_CODE_INITIAL;
      endcase
      return c;
   endfunction

endpackage

FILE: design/bbmc_req_if.sv
`timescale 1ns / 1ps

interface bbmc_req_if;
   logic                                          valid;
   logic                                          ready;
   logic [bbmc_pkg::LEVEL_W-1:0]                  system_level;
   logic [bbmc_pkg::LEVEL_W-1:0]                  battery_level;
   logic signed [bbmc_pkg::TEMP_W-1:0]            battery_temperature;
   logic [bbmc_pkg::LEVEL_W-1:0]                  current_magnitude;
   logic [bbmc_pkg::PCT_W-1:0]                    charge_percent;

   modport source (output valid, system_level, battery_level, battery_temperature,
                   current_magnitude, charge_percent, input ready);
   modport sink   (input valid, system_level, battery_level, battery_temperature,
                   current_magnitude, charge_percent, output ready);
endinterface

FILE: design/bbmc_rsp_if.sv
`timescale 1ns / 1ps

interface bbmc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bbmc_pkg::MODE_W-1:0]       mode;
   logic                              charge_relay;
   logic                              buck_output_off;
   logic                              heater_relay;
   logic                              boost_input_relay;
   logic                              fan_on;
   logic                              discharge_led;
   logic                              charge_led;
   logic [bbmc_pkg::LAMPS-1:0]        level_leds;

   modport source (output valid, mode, charge_relay, buck_output_off, heater_relay,
                   boost_input_relay, fan_on, discharge_led, charge_led, level_leds,
                   input ready);
   modport sink   (input valid, mode, charge_relay, buck_output_off, heater_relay,
                   boost_input_relay, fan_on, discharge_led, charge_led, level_leds,
                   output ready);
endinterface

FILE: design/bbmc_csr.sv
`timescale 1ns / 1ps

module bbmc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               write_enable,
   input  logic [bbmc_pkg::CSR_IDX_W-1:0]     index,
   input  logic [bbmc_pkg::CSR_DAT_W-1:0]     write_data,
   output bbmc_pkg::cfg_type                  cfg
);

   bbmc_pkg::cfg_type cfg_ff;
   bbmc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         unique case (index)
            bbmc_pkg::CSR_BATTERY_PRESENT: cfg_in.battery_present = write_data;
            bbmc_pkg::CSR_BATTERY_EMPTY:   cfg_in.battery_empty   = write_data;
            bbmc_pkg::CSR_BATTERY_FULL:    cfg_in.battery_full    = write_data;
            bbmc_pkg::CSR_SUPPLY_START:    cfg_in.supply_start    = write_data;
            bbmc_pkg::CSR_SUPPLY_STOP:     cfg_in.supply_stop     = write_data;
            bbmc_pkg::CSR_CHARGE_START:    cfg_in.charge_start    = write_data;
            bbmc_pkg::CSR_CHARGE_STOP:     cfg_in.charge_stop     = write_data;
            bbmc_pkg::CSR_TEMP_LIMIT:
               cfg_in.temp_limit = signed'(write_data[bbmc_pkg::TEMP_W-1:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_present <= bbmc_pkg::RST_BATTERY_PRESENT;
         cfg_ff.battery_empty   <= bbmc_pkg::RST_BATTERY_EMPTY;
         cfg_ff.battery_full    <= bbmc_pkg::RST_BATTERY_FULL;
         cfg_ff.supply_start    <= bbmc_pkg::RST_SUPPLY_START;
         cfg_ff.supply_stop     <= bbmc_pkg::RST_SUPPLY_STOP;
         cfg_ff.charge_start    <= bbmc_pkg::RST_CHARGE_START;
         cfg_ff.charge_stop     <= bbmc_pkg::RST_CHARGE_STOP;
         cfg_ff.temp_limit      <= bbmc_pkg::RST_TEMP_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/bbmc_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one tick. Purely combinational.
module bbmc_step (
   input  bbmc_pkg::cfg_type    cfg,
   input  bbmc_pkg::state_type  state,
   input  bbmc_pkg::req_type    req,
   output bbmc_pkg::state_type  state_next,
   output bbmc_pkg::rsp_type    rsp
);

   logic [bbmc_pkg::LAMPS-1:0]   lit;
   logic [bbmc_pkg::LAMPS:0]     lit_inc;
   logic [bbmc_pkg::LAMPS-1:0]   lamps;
   logic                         blink;
   logic                         chg_ok;
   logic                         stop;
   bbmc_pkg::state_type          nx;

   // Level lamps are a thermometer code, so the first unlit lamp is the
   // single bit that lit + 1 adds.
   always_comb begin
      for (int i = 0; i < bbmc_pkg::LAMPS; i++) begin
         lit[i] = req.charge_percent > bbmc_pkg::LAMP_LIMIT[i];
      end
      lit_inc = {1'b0, lit} + {{bbmc_pkg::LAMPS{1'b0}}, 1'b1};
      lamps   = (state.relays.chg_led && blink) ? (lit | lit_inc[bbmc_pkg::LAMPS-1:0]) : lit;
   end

   assign blink = ~state.blink;

   always_comb begin
      nx       = state;
      nx.blink = blink;
      chg_ok   = 1'b0;
      stop     = 1'b0;
      if (state.mode != bbmc_pkg::MODE_INITIAL) begin
         nx.lamps = lamps;
      end

      if (state.holdoff != '0) begin
         nx.holdoff = state.holdoff - 1'b1;
      end else begin
         unique case (state.mode)
            bbmc_pkg::MODE_INITIAL: begin
               nx.relays = bbmc_pkg::RELAY_RESET;
               nx.lamps  = '0;
               if (req.battery_level > cfg.battery_present) begin
                  nx.mode    = bbmc_pkg::MODE_READY;
                  nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
               end else begin
                  nx.relays.dis_led = blink;
                  nx.relays.chg_led = ~blink;
               end
            end

            bbmc_pkg::MODE_READY: begin
               nx.relays.dis_led = 1'b0;
               nx.relays.chg_led = 1'b0;
               if (req.battery_level >= cfg.battery_present) begin
                  priority if (req.system_level <= cfg.supply_start) begin
                     nx.mode    = bbmc_pkg::MODE_SUPPLYING;
                     nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
                  end else if (req.system_level >= cfg.charge_start) begin
                     nx.mode    = bbmc_pkg::MODE_CHARGING;
                     nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
                  end else if (req.battery_level <= cfg.battery_empty) begin
                     nx.mode    = bbmc_pkg::MODE_EMPTY;
                     nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
                  end else begin
                     nx.mode = state.mode;
                  end
               end
            end

            bbmc_pkg::MODE_SUPPLYING: begin
               nx.relays.dis_led  = 1'b1;
               nx.relays.buck_off = req.battery_temperature > cfg.temp_limit;
               priority if (req.system_level >= cfg.supply_stop) begin
                  stop       = 1'b1;
                  nx.mode    = bbmc_pkg::MODE_READY;
                  nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
               end else if (req.battery_level <= cfg.battery_empty) begin
                  stop       = 1'b1;
                  nx.mode    = bbmc_pkg::MODE_EMPTY;
                  nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
               end else begin
                  stop = 1'b0;
               end
               if (stop) begin
                  nx.relays.dis_led  = 1'b0;
                  nx.relays.buck_off = 1'b1;
               end
            end

            bbmc_pkg::MODE_EMPTY: begin
               nx.relays.dis_led = blink;
               if (req.system_level >= cfg.charge_start) begin
                  nx.relays.dis_led = 1'b0;
                  nx.mode           = bbmc_pkg::MODE_CHARGING;
                  nx.holdoff        = bbmc_pkg::HOLD_MODE_CHANGE;
               end
            end

            bbmc_pkg::MODE_CHARGING: begin
               nx.relays.heater = req.battery_temperature < bbmc_pkg::HEATER_LEVEL;
               chg_ok = (state.charging ||
                         req.battery_temperature >= bbmc_pkg::CHARGE_MIN_TEMPERATURE) &&
                        req.battery_temperature <= cfg.temp_limit;
               if (chg_ok) begin
                  if (!state.charging) begin
                     nx.relays.chg_led = 1'b1;
                     nx.relays.fan     = 1'b1;
                     nx.relays.boost   = 1'b1;
                     nx.charging       = 1'b1;
                  end
               end else begin
                  nx.relays.chg_led   = blink;
                  nx.relays.fan       = 1'b0;
                  nx.relays.boost     = 1'b0;
                  nx.relays.chg_relay = 1'b0;
                  nx.charging         = 1'b0;
               end

               // Close the relay first, then let it settle; on low current
               // below full, open it again and retry after a short wait.
               priority if (nx.charging && !nx.relays.chg_relay) begin
                  nx.relays.chg_relay = 1'b1;
                  nx.holdoff          = bbmc_pkg::HOLD_RELAY_CLOSE;
               end else if (req.system_level <= cfg.charge_stop) begin
                  stop       = 1'b1;
                  nx.mode    = bbmc_pkg::MODE_READY;
                  nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
               end else if (nx.charging &&
                            req.current_magnitude <= bbmc_pkg::MIN_CHARGE_CURRENT) begin
                  if (req.battery_level >= cfg.battery_full) begin
                     stop       = 1'b1;
                     nx.mode    = bbmc_pkg::MODE_FULL;
                     nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
                  end else begin
                     nx.relays.chg_relay = 1'b0;
                     nx.holdoff          = bbmc_pkg::HOLD_RELAY_RETRY;
                  end
               end else begin
                  stop = 1'b0;
               end

               if (stop) begin
                  nx.charging         = 1'b0;
                  nx.relays.chg_led   = 1'b0;
                  nx.relays.fan       = 1'b0;
                  nx.relays.boost     = 1'b0;
                  nx.relays.chg_relay = 1'b0;
                  nx.relays.heater    = 1'b0;
               end
            end

            bbmc_pkg::MODE_FULL: begin
               if (req.system_level <= cfg.charge_stop) begin
                  nx.mode    = bbmc_pkg::MODE_READY;
                  nx.holdoff = bbmc_pkg::HOLD_MODE_CHANGE;
               end
            end

            default: nx = state;
         endcase
      end
   end

   assign state_next = nx;

   always_comb begin
      rsp.mode              = bbmc_pkg::mode_code(nx.mode);
      rsp.charge_relay      = nx.relays.chg_relay;
      rsp.buck_output_off   = nx.relays.buck_off;
      rsp.heater_relay      = nx.relays.heater;
      rsp.boost_input_relay = nx.relays.boost;
      rsp.fan_on            = nx.relays.fan;
      rsp.discharge_led     = nx.relays.dis_led;
      rsp.charge_led        = nx.relays.chg_led;
      rsp.level_leds        = nx.lamps;
   end

endmodule

FILE: design/battery_backup_mode_controller.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_port  in         system_level, battery_level, battery_temperature,
//                      current_magnitude, charge_percent (one tick)
// rsp_port  out        mode, five relay and fan bits, two indicator lamps,
//                      level_leds (one result per tick)
// csr_*     in         write enable, register index 0..7, 16-bit write data
//
// Each tick beat yields exactly one result beat. The accepting edge loads the
// input register, and the beat passes through the step logic into the result
// register at an edge where the result register is empty or its beat is taken.
// A new beat can be taken every cycle; throughput is one beat per clock unless
// the result side holds off.
// Reset is synchronous and active high; it returns the controller to the
// initial mode with the buck output off and all configuration at defaults.
// When the result register is full and not taken, the input register holds
// its beat and req_port.ready drops once the input register is also full.

module battery_backup_mode_controller (
   input  logic                               clock,
   input  logic                               reset,
   bbmc_req_if.sink                           req_port,
   bbmc_rsp_if.source                         rsp_port,
   input  logic                               csr_write_enable,
   input  logic [bbmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbmc_pkg::CSR_DAT_W-1:0]     csr_write_data
);

   bbmc_pkg::cfg_type    cfg;

   // Input register stage.
   logic                 in_valid_ff;
   logic                 in_valid_in;
   bbmc_pkg::req_type    in_data_ff;
   bbmc_pkg::req_type    in_data_in;

   // Controller state, updated when a beat moves into the result register.
   bbmc_pkg::state_type  state_ff;
   bbmc_pkg::state_type  state_in;
   bbmc_pkg::state_type  step_state;

   // Result register stage.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   bbmc_pkg::rsp_type    rsp_data_ff;
   bbmc_pkg::rsp_type    rsp_data_in;
   bbmc_pkg::rsp_type    step_rsp;

   logic                 advance;
   logic                 req_take;

   bbmc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   bbmc_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .req        (in_data_ff),
      .state_next (step_state),
      .rsp        (step_rsp)
   );

   // A buffered tick moves on whenever the result register is empty or its
   // beat is being taken in this cycle.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take = req_port.valid && req_port.ready;

   always_comb begin
      in_data_in.system_level        = req_port.system_level;
      in_data_in.battery_level       = req_port.battery_level;
      in_data_in.battery_temperature = req_port.battery_temperature;
      in_data_in.current_magnitude   = req_port.current_magnitude;
      in_data_in.charge_percent      = req_port.charge_percent;
   end

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign state_in     = advance ? step_state : state_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_port.ready);
   assign rsp_data_in  = step_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         state_ff.mode    <= bbmc_pkg::MODE_INITIAL;
         state_ff.holdoff <= '0;
         state_ff.blink   <= 1'b0;
         state_ff.charging <= 1'b0;
         state_ff.relays  <= bbmc_pkg::RELAY_RESET;
         state_ff.lamps   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.mode              = rsp_data_ff.mode;
   assign rsp_port.charge_relay      = rsp_data_ff.charge_relay;
   assign rsp_port.buck_output_off   = rsp_data_ff.buck_output_off;
   assign rsp_port.heater_relay      = rsp_data_ff.heater_relay;
   assign rsp_port.boost_input_relay = rsp_data_ff.boost_input_relay;
   assign rsp_port.fan_on            = rsp_data_ff.fan_on;
   assign rsp_port.discharge_led     = rsp_data_ff.discharge_led;
   assign rsp_port.charge_led        = rsp_data_ff.charge_led;
   assign rsp_port.level_leds        = rsp_data_ff.level_leds;

endmodule

FILE: test/tb_battery_backup_mode_controller.sv
`timescale 1ns / 1ps

// Self-checking bench for the battery backup mode controller. Every accepted tick beat is
// run through a predictor that keeps its own copy of the mode, hold-off, blink, relay
// and lamp state. Each result beat is then compared field by field with the oldest
// prediction still waiting.
module tb_battery_backup_mode_controller;

   typedef logic [bbmc_pkg::LEVEL_W-1:0]          level_type;
   typedef logic signed [bbmc_pkg::TEMP_W-1:0]    temp_type;
   typedef logic [bbmc_pkg::PCT_W-1:0]            pct_type;
   typedef logic [bbmc_pkg::CSR_IDX_W-1:0]        index_type;
   typedef logic [bbmc_pkg::HOLD_W-1:0]           hold_type;

   // Fixed thresholds of the controller, as the behavior defines them.
   localparam int WARM_LIMIT       = 50;
   localparam int COLD_LIMIT       = 0;
   localparam int LOW_CURRENT      = 100;
   localparam int LAMP_STEPS [5]   = '{10, 30, 50, 70, 90};
   localparam hold_type HOLD_AFTER_SWITCH = 4'd8;
   localparam hold_type HOLD_AFTER_CLOSE  = 4'd6;
   localparam hold_type HOLD_AFTER_RETRY  = 4'd4;

   // The block has two register stages, so a few edges cover any beat still in flight.
   localparam int SETTLE_CYCLES    = 4;
   // The receiver holds off long enough for both register stages to fill and stall input.
   localparam int LONG_HOLD_CYCLES = 100;

   // Kinds of tick bursts. Most of them steer the rails into one mode's thresholds,
   // so that the mode sequence gets past its hold-off periods and into the deeper rules.
   typedef enum int {
      RG_CHARGE,
      RG_SUPPLY,
      RG_LOW_BATTERY,
      RG_EDGES,
      RG_NOISE
   } regime_type;

   class tick_scoreboard;
      bbmc_pkg::rsp_type expected_q [$];
      int errors = 0;
      int reported = 0;
      int checked = 0;
      int mode_hits [8];

      logic [bbmc_pkg::MODE_W-1:0]  mode_q = bbmc_pkg::MODE_CODE_INITIAL;
      hold_type                     hold_q = '0;
      bit                           blink_q = 1'b0;
      bit                           active_q = 1'b0;
      bbmc_pkg::relay_type          relays_q = 7'b0000010;
      logic [bbmc_pkg::LAMPS-1:0]   lamps_q = '0;

      level_type present_lvl = 16'd9000;
      level_type empty_lvl   = 16'd11000;
      level_type full_lvl    = 16'd13800;
      level_type sup_start   = 16'd11500;
      level_type sup_stop    = 16'd12500;
      level_type chg_start   = 16'd13000;
      level_type chg_stop    = 16'd12300;
      int        temp_lim    = 450;

      function void write_reg(index_type idx, logic [bbmc_pkg::CSR_DAT_W-1:0] data);
         case (idx)
            bbmc_pkg::CSR_BATTERY_PRESENT: present_lvl = data;
            bbmc_pkg::CSR_BATTERY_EMPTY:   empty_lvl = data;
            bbmc_pkg::CSR_BATTERY_FULL:    full_lvl = data;
            bbmc_pkg::CSR_SUPPLY_START:    sup_start = data;
            bbmc_pkg::CSR_SUPPLY_STOP:     sup_stop = data;
            bbmc_pkg::CSR_CHARGE_START:    chg_start = data;
            bbmc_pkg::CSR_CHARGE_STOP:     chg_stop = data;
            bbmc_pkg::CSR_TEMP_LIMIT:
               temp_lim = int'($signed(data[bbmc_pkg::TEMP_W-1:0]));
            default: ;
         endcase
      endfunction

      function void switch_to(logic [bbmc_pkg::MODE_W-1:0] m);
         mode_q = m;
         hold_q = HOLD_AFTER_SWITCH;
      endfunction

      function bbmc_pkg::rsp_type outputs();
         bbmc_pkg::rsp_type r;
         r.mode              = mode_q;
         r.charge_relay      = relays_q.chg_relay;
         r.buck_output_off   = relays_q.buck_off;
         r.heater_relay      = relays_q.heater;
         r.boost_input_relay = relays_q.boost;
         r.fan_on            = relays_q.fan;
         r.discharge_led     = relays_q.dis_led;
         r.charge_led        = relays_q.chg_led;
         r.level_leds        = lamps_q;
         return r;
      endfunction

      function bbmc_pkg::rsp_type step(bbmc_pkg::req_type t);
         logic [bbmc_pkg::LAMPS-1:0] lv;
         bit seen_gap;
         bit stop;
         int temp;
         temp = int'(t.battery_temperature);
         stop = 1'b0;
         blink_q = !blink_q;
         if (mode_q != bbmc_pkg::MODE_CODE_INITIAL) begin
            lv = '0;
            for (int i = 0; i < bbmc_pkg::LAMPS; i++)
               if (t.charge_percent > LAMP_STEPS[i]) lv[i] = 1'b1;
            // While charging is shown, the first dark lamp follows the blink phase.
            if (relays_q.chg_led) begin
               seen_gap = 1'b0;
               for (int i = 0; i < bbmc_pkg::LAMPS; i++) begin
                  if (!seen_gap && !lv[i]) begin
                     lv[i] = blink_q;
                     seen_gap = 1'b1;
                  end
               end
            end
            lamps_q = lv;
         end
         if (hold_q != 0) begin
            hold_q = hold_q - 1'b1;
            return outputs();
         end
         case (mode_q)
            bbmc_pkg::MODE_CODE_INITIAL: begin
               relays_q = '0;
               relays_q.buck_off = 1'b1;
               lamps_q = '0;
               if (t.battery_level > present_lvl) begin
                  switch_to(bbmc_pkg::MODE_CODE_READY);
               end else begin
                  relays_q.dis_led = blink_q;
                  relays_q.chg_led = !blink_q;
               end
            end
            bbmc_pkg::MODE_CODE_READY: begin
               relays_q.dis_led = 1'b0;
               relays_q.chg_led = 1'b0;
               if (t.battery_level >= present_lvl) begin
                  if (t.system_level <= sup_start)
                     switch_to(bbmc_pkg::MODE_CODE_SUPPLYING);
                  else if (t.system_level >= chg_start)
                     switch_to(bbmc_pkg::MODE_CODE_CHARGING);
                  else if (t.battery_level <= empty_lvl)
                     switch_to(bbmc_pkg::MODE_CODE_EMPTY);
               end
            end
            bbmc_pkg::MODE_CODE_SUPPLYING: begin
               relays_q.dis_led = 1'b1;
               relays_q.buck_off = temp > temp_lim;
               if (t.system_level >= sup_stop) begin
                  stop = 1'b1;
                  switch_to(bbmc_pkg::MODE_CODE_READY);
               end else if (t.battery_level <= empty_lvl) begin
                  stop = 1'b1;
                  switch_to(bbmc_pkg::MODE_CODE_EMPTY);
               end
               if (stop) begin
                  relays_q.dis_led = 1'b0;
                  relays_q.buck_off = 1'b1;
               end
            end
            bbmc_pkg::MODE_CODE_EMPTY: begin
               relays_q.dis_led = blink_q;
               if (t.system_level >= chg_start) begin
                  relays_q.dis_led = 1'b0;
                  switch_to(bbmc_pkg::MODE_CODE_CHARGING);
               end
            end
            bbmc_pkg::MODE_CODE_CHARGING: begin
               relays_q.heater = temp < WARM_LIMIT;
               if ((active_q || temp >= COLD_LIMIT) && temp <= temp_lim) begin
                  if (!active_q) begin
                     relays_q.chg_led = 1'b1;
                     relays_q.fan = 1'b1;
                     relays_q.boost = 1'b1;
                     active_q = 1'b1;
                  end
               end else begin
                  relays_q.chg_led = blink_q;
                  relays_q.fan = 1'b0;
                  relays_q.boost = 1'b0;
                  relays_q.chg_relay = 1'b0;
                  active_q = 1'b0;
               end
               if (active_q && !relays_q.chg_relay) begin
                  relays_q.chg_relay = 1'b1;
                  hold_q = HOLD_AFTER_CLOSE;
                  return outputs();
               end
               if (t.system_level <= chg_stop) begin
                  stop = 1'b1;
                  switch_to(bbmc_pkg::MODE_CODE_READY);
               end else if (active_q && t.current_magnitude <= LOW_CURRENT) begin
                  if (t.battery_level >= full_lvl) begin
                     stop = 1'b1;
                     switch_to(bbmc_pkg::MODE_CODE_FULL);
                  end else begin
                     // Too little current: open the relay and retry after a pause.
                     relays_q.chg_relay = 1'b0;
                     hold_q = HOLD_AFTER_RETRY;
                     return outputs();
                  end
               end
               if (stop) begin
                  active_q = 1'b0;
                  relays_q.chg_led = 1'b0;
                  relays_q.fan = 1'b0;
                  relays_q.boost = 1'b0;
                  relays_q.chg_relay = 1'b0;
                  relays_q.heater = 1'b0;
               end
            end
            bbmc_pkg::MODE_CODE_FULL: begin
               if (t.system_level <= chg_stop) switch_to(bbmc_pkg::MODE_CODE_READY);
            end
            default: ;
         endcase
         return outputs();
      endfunction

      function void note_tick(bbmc_pkg::req_type t);
         bbmc_pkg::rsp_type r;
         r = step(t);
         expected_q.push_back(r);
         mode_hits[r.mode]++;
      endfunction

      function void compare_field(string name, logic [7:0] e, logic [7:0] a);
         if (a !== e) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                        name, checked, e, a);
            end
         end
      endfunction

      function void check_result(bbmc_pkg::rsp_type got);
         bbmc_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("Result beat with no tick waiting for it, mode %0h", got.mode);
            end
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare_field("mode", 8'(e.mode), 8'(got.mode));
         compare_field("charge_relay", 8'(e.charge_relay), 8'(got.charge_relay));
         compare_field("buck_output_off", 8'(e.buck_output_off), 8'(got.buck_output_off));
         compare_field("heater_relay", 8'(e.heater_relay), 8'(got.heater_relay));
         compare_field("boost_input_relay", 8'(e.boost_input_relay),
                       8'(got.boost_input_relay));
         compare_field("fan_on", 8'(e.fan_on), 8'(got.fan_on));
         compare_field("discharge_led", 8'(e.discharge_led), 8'(got.discharge_led));
         compare_field("charge_led", 8'(e.charge_led), 8'(got.charge_led));
         compare_field("level_leds", 8'(e.level_leds), 8'(got.level_leds));
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 csr_write_enable;
   index_type                            csr_index;
   logic [bbmc_pkg::CSR_DAT_W-1:0]       csr_write_data;

   bbmc_req_if req_bus ();
   bbmc_rsp_if rsp_bus ();

   battery_backup_mode_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tick_scoreboard sb;

   // Idling controls shared by the sender and the receiver.
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   bit long_hold_request = 1'b0;

   int ticks_sent = 0;
   int settings_applied = 0;
   logic [bbmc_pkg::CSR_DAT_W-1:0] setting [8];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // A fixed ceiling on the run. The slowest correct run takes well under a tenth of it.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // Result side. Each beat taken at an edge is checked against the oldest prediction,
   // and the next value of ready is chosen once per edge so that it gets a single
   // nonblocking assignment. A long hold requested by the stimulus is counted here.
   initial begin : result_sink
      bbmc_pkg::rsp_type got;
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.mode              = rsp_bus.mode;
            got.charge_relay      = rsp_bus.charge_relay;
            got.buck_output_off   = rsp_bus.buck_output_off;
            got.heater_relay      = rsp_bus.heater_relay;
            got.boost_input_relay = rsp_bus.boost_input_relay;
            got.fan_on            = rsp_bus.fan_on;
            got.discharge_led     = rsp_bus.discharge_led;
            got.charge_led        = rsp_bus.charge_led;
            got.level_leds        = rsp_bus.level_leds;
            sb.check_result(got);
         end
         if (long_hold_request && hold_left == 0) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = int'($urandom_range(1, 5)) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offers one tick beat and returns at the edge where it is taken. When there is no
   // gap, valid simply stays high and only the payload changes.
   task automatic send_tick(input bbmc_pkg::req_type t);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.system_level        <= t.system_level;
      req_bus.battery_level       <= t.battery_level;
      req_bus.battery_temperature <= t.battery_temperature;
      req_bus.current_magnitude   <= t.current_magnitude;
      req_bus.charge_percent      <= t.charge_percent;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_tick(t);
      ticks_sent++;
   endtask

   task automatic send_fields(input int sys, input int bat, input int temp, input int cur,
                              input int pct);
      bbmc_pkg::req_type t;
      t.system_level        = level_type'(sys);
      t.battery_level       = level_type'(bat);
      t.battery_temperature = temp_type'(temp);
      t.current_magnitude   = level_type'(cur);
      t.charge_percent      = pct_type'(pct);
      send_tick(t);
   endtask

   // Stops offering beats and waits until every predicted result has been taken.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all eight registers from the setting array, one per edge, with the block idle.
   task automatic apply_setting();
      wait_idle();
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= index_type'(i);
         csr_write_data   <= setting[i];
         @(posedge clock);
         sb.write_reg(index_type'(i), setting[i]);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   // A realistic ordering of thresholds with random spacing. The upper bits of the
   // temperature word are junk on purpose; only its low eleven bits count.
   task automatic choose_typical_setting();
      int p;
      int e;
      int ss;
      int sp;
      int cs;
      p  = $urandom_range(7000, 10000);
      e  = p + $urandom_range(500, 2500);
      ss = $urandom_range(10500, 12000);
      sp = ss + $urandom_range(300, 1500);
      cs = sp + $urandom_range(0, 1000);
      setting[bbmc_pkg::CSR_BATTERY_PRESENT] = level_type'(p);
      setting[bbmc_pkg::CSR_BATTERY_EMPTY]   = level_type'(e);
      setting[bbmc_pkg::CSR_BATTERY_FULL]    = level_type'(e + $urandom_range(1500, 3500));
      setting[bbmc_pkg::CSR_SUPPLY_START]    = level_type'(ss);
      setting[bbmc_pkg::CSR_SUPPLY_STOP]     = level_type'(sp);
      setting[bbmc_pkg::CSR_CHARGE_START]    = level_type'(cs);
      setting[bbmc_pkg::CSR_CHARGE_STOP]     = level_type'(cs - $urandom_range(200, 900));
      setting[bbmc_pkg::CSR_TEMP_LIMIT]      = {5'($urandom), 11'($urandom_range(100, 900))};
   endtask

   task automatic choose_extreme_setting(input bit high);
      for (int i = 0; i < 8; i++) setting[i] = high ? 16'hFFFF : 16'h0000;
      setting[bbmc_pkg::CSR_TEMP_LIMIT] = high ? 16'h03FF : 16'hFC00;
   endtask

   // A level a few counts around a threshold, clipped to the sensor range.
   function automatic level_type near(input int lvl, input int spread);
      int v;
      v = lvl + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return level_type'(v);
   endfunction

   function automatic bbmc_pkg::req_type make_tick(input regime_type rg);
      bbmc_pkg::req_type t;
      int temp;
      int pick;
      t.system_level      = level_type'($urandom);
      t.battery_level     = level_type'($urandom);
      t.current_magnitude = level_type'($urandom);
      t.charge_percent    = pct_type'($urandom_range(0, 100));
      if ($urandom_range(0, 9) == 0) t.charge_percent = pct_type'($urandom_range(101, 127));
      // Temperatures mostly straddle the freezing and heater points, some sit right at
      // the limit, and the rest span the whole sensor range.
      pick = $urandom_range(0, 19);
      if (pick < 13) temp = int'($urandom_range(0, 100)) - 20;
      else if (pick < 17) temp = sb.temp_lim + int'($urandom_range(0, 6)) - 3;
      else temp = int'($urandom_range(0, 2047)) - 1024;
      if (temp < -1024) temp = -1024;
      if (temp > 1023) temp = 1023;
      t.battery_temperature = temp_type'(temp);
      pick = $urandom_range(0, 9);
      if (pick < 5) t.current_magnitude = level_type'($urandom_range(0, 150));
      else if (pick == 5) t.current_magnitude = level_type'($urandom_range(100, 101));
      case (rg)
         RG_CHARGE: begin
            t.system_level = ($urandom_range(0, 9) == 0) ? near(int'(sb.chg_stop), 4)
                             : near(int'(sb.chg_start) + 600, 600);
            t.battery_level = ($urandom_range(0, 1) == 0) ? near(int'(sb.full_lvl), 150)
                              : near(int'(sb.full_lvl), 3000);
         end
         RG_SUPPLY: begin
            t.system_level = ($urandom_range(0, 7) == 0) ? near(int'(sb.sup_stop), 4)
                             : near(int'(sb.sup_start) - 600, 600);
            t.battery_level = ($urandom_range(0, 7) == 0) ? near(int'(sb.empty_lvl), 4)
                              : near(int'(sb.empty_lvl) + 800, 700);
         end
         RG_LOW_BATTERY: begin
            t.system_level = ($urandom_range(0, 5) == 0) ? near(int'(sb.chg_start), 4)
                             : near((int'(sb.sup_start) + int'(sb.chg_start)) / 2, 300);
            t.battery_level = near(int'(sb.empty_lvl), 600);
         end
         RG_EDGES: begin
            pick = $urandom_range(0, 4);
            case (pick)
               0: t.system_level = near(int'(sb.sup_start), 2);
               1: t.system_level = near(int'(sb.sup_stop), 2);
               2: t.system_level = near(int'(sb.chg_start), 2);
               default: t.system_level = near(int'(sb.chg_stop), 2);
            endcase
            pick = $urandom_range(0, 2);
            case (pick)
               0: t.battery_level = near(int'(sb.present_lvl), 2);
               1: t.battery_level = near(int'(sb.empty_lvl), 2);
               default: t.battery_level = near(int'(sb.full_lvl), 2);
            endcase
         end
         default: ;
      endcase
      return t;
   endfunction

   // Random tick beats in bursts, each burst steered at one kind of behavior. With
   // pressure on, halfway through the receiver holds off for a long stretch while beats
   // keep coming, and at three quarters the sender waits until every result is in.
   task automatic run_random(input int count, input bit pressure, input bit quiet);
      regime_type rg;
      int done;
      int len;
      int pick;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 6) rg = RG_CHARGE;
         else if (pick < 10) rg = RG_SUPPLY;
         else if (pick < 13) rg = RG_LOW_BATTERY;
         else if (pick < 17) rg = RG_EDGES;
         else rg = RG_NOISE;
         len = $urandom_range(5, 40);
         if (!quiet) begin
            gaps_on   = $urandom_range(0, 9) < 7;
            stalls_on = $urandom_range(0, 9) < 7;
         end
         for (int k = 0; k < len && done < count; k++) begin
            if (pressure && done == count / 2) long_hold_request = 1'b1;
            if (pressure && done == (3 * count) / 4) begin
               req_bus.valid <= 1'b0;
               do @(posedge clock); while (sb.expected_q.size() != 0);
            end
            send_tick(make_tick(rg));
            done++;
         end
      end
   endtask

   // Hand-picked ticks at the reset thresholds: the presence test on both sides of its
   // level, the hold-off after entering ready used to sweep every field to its extremes
   // and every lamp step including a charge above one hundred percent, entry into supply
   // at the exact start level, the buck output on both sides of the temperature limit,
   // and the return to ready at the stop level.
   task automatic directed_ticks();
      send_fields(0, 0, -1024, 0, 0);
      send_fields(65535, 9000, 1023, 65535, 127);
      send_fields(12000, 9001, 25, 0, 50);
      send_fields(65535, 65535, 1023, 65535, 10);
      send_fields(0, 0, -1024, 0, 11);
      send_fields(65535, 0, 0, 65535, 30);
      send_fields(0, 65535, -1, 0, 31);
      send_fields(12000, 12000, 450, 100, 70);
      send_fields(12000, 12000, 451, 101, 71);
      send_fields(12000, 12000, 49, 100, 90);
      send_fields(12000, 12000, 50, 99, 127);
      send_fields(11500, 9000, 25, 500, 100);
      for (int k = 0; k < 8; k++) send_fields(11000, 12000, 25, 500, k * 14);
      send_fields(11000, 12000, 451, 500, 55);
      send_fields(11000, 12000, 450, 500, 55);
      send_fields(12500, 12000, 25, 500, 55);
   endtask

   initial begin : stimulus
      sb = new;
      reset                       = 1'b1;
      csr_write_enable            = 1'b0;
      csr_index                   = '0;
      csr_write_data              = '0;
      req_bus.valid               = 1'b0;
      req_bus.system_level        = '0;
      req_bus.battery_level       = '0;
      req_bus.battery_temperature = '0;
      req_bus.current_magnitude   = '0;
      req_bus.charge_percent      = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The reset thresholds first, then a realistic setting with the pressure tests,
      // both extremes, and a second realistic setting that ends with no idling at all.
      directed_ticks();
      run_random(380, 1'b0, 1'b0);
      choose_typical_setting();
      apply_setting();
      run_random(400, 1'b1, 1'b0);
      choose_extreme_setting(1'b0);
      apply_setting();
      run_random(150, 1'b0, 1'b0);
      choose_extreme_setting(1'b1);
      apply_setting();
      run_random(150, 1'b0, 1'b0);
      choose_typical_setting();
      apply_setting();
      run_random(300, 1'b0, 1'b0);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      run_random(150, 1'b0, 1'b1);
      wait_idle();

      $display("Ran %0d tick beats under %0d written threshold settings, %0d results checked.",
               ticks_sent, settings_applied, sb.checked);
      $display("Predicted beats per mode, initial through full: %0d %0d %0d %0d %0d %0d",
               sb.mode_hits[bbmc_pkg::MODE_CODE_INITIAL],
               sb.mode_hits[bbmc_pkg::MODE_CODE_READY],
               sb.mode_hits[bbmc_pkg::MODE_CODE_SUPPLYING],
               sb.mode_hits[bbmc_pkg::MODE_CODE_EMPTY],
               sb.mode_hits[bbmc_pkg::MODE_CODE_CHARGING],
               sb.mode_hits[bbmc_pkg::MODE_CODE_FULL]);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
